// ===== rtl/ldasa_pkg.sv =====
// shared types, codes and correction table math for the log-domain add/sub unit
`timescale 1ns / 1ps
package ldasa_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_TABLE_DEPTH = 1024;

  // tables span differences in [0, 2^RANGE_LOG2)
  localparam int RANGE_LOG2 = 4;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint          LN2_Q30 = 64'sd744261118;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_ACC = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    K_FIN  = 3'd0,
    K_MISS = 3'd1,
    K_PINF = 3'd2,
    K_NINF = 3'd3,
    K_BAD  = 3'd4
  } kind_t;

  // control word handed from the front stage to the correction stage
  typedef struct packed {
    kind_t kind;
    logic  corr_en;
    logic  use_sub;
    logic  is_acc;
  } ctl_t;

  typedef struct packed {
    kind_t kind;
    logic  take_b;
  } nf_t;

  // ordering with +inf > finite > -inf, missing yields the other operand
  function automatic nf_t nf_max(kind_t ka, kind_t kb);
    nf_t r;
    r.kind   = ka;
    r.take_b = 1'b0;
    if (ka == K_MISS) begin
      r.kind   = kb;
      r.take_b = 1'b1;
    end else if (kb == K_MISS) begin
      r.kind = ka;
    end else if (ka == K_PINF || kb == K_PINF) begin
      r.kind = K_PINF;
    end else if (ka == K_NINF) begin
      r.kind   = kb;
      r.take_b = 1'b1;
    end
    return r;
  endfunction

  // unsigned quotient by restoring shift and subtract, table build only
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int n = 63; n >= 0; n--) begin
      rem = {rem[62:0], num[n]};
      if (rem >= den) begin
        rem  = rem - den;
        q[n] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-d in q30, d in q30: taylor series on d/256 then eight squarings
  function automatic longint unsigned exp_neg_q30(longint unsigned d);
    longint unsigned r;
    longint unsigned term;
    longint unsigned sum;
    r    = d >> 8;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int i = 1; i <= 10; i++) begin
      term = udiv((term * r) >> 30, longint'(i));
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    for (int i = 0; i < 8; i++) begin
      sum = (sum * sum + (64'd1 << 29)) >> 30;
    end
    return sum;
  endfunction

  // natural log in q30 via normalization to [1,2) and an atanh series
  function automatic longint ln_q30(longint y);
    longint unsigned m;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned acc;
    longint          s;
    longint          yy;
    yy  = (y <= 0) ? 64'sd1 : y;
    m   = longint'(yy);
    s   = 0;
    acc = 0;
    for (int j = 0; j < 64; j++) begin
      if (m < Q30_ONE) begin
        m = m << 1;
        s = s - 1;
      end
    end
    for (int j = 0; j < 64; j++) begin
      if (m >= 2 * Q30_ONE) begin
        m = m >> 1;
        s = s + 1;
      end
    end
    z  = udiv((m - Q30_ONE) << 30, m + Q30_ONE);
    z2 = (z * z) >> 30;
    p  = z;
    for (int k = 1; k <= 39; k += 2) begin
      acc = acc + udiv(p, longint'(k));
      p   = (p * z2) >> 30;
    end
    return 2 * longint'(acc) + s * LN2_Q30;
  endfunction

  // q30 to frac_bits, rounding half away from zero
  function automatic longint to_frac(longint v, int frac);
    logic            neg;
    longint unsigned mag;
    int              sh;
    neg = (v < 0);
    mag = neg ? longint'(-v) : longint'(v);
    sh  = 30 - frac;
    if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
    else if (sh < 0) mag = mag << (-sh);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint add_entry(longint unsigned dq, int frac);
    return to_frac(ln_q30(longint'(Q30_ONE + exp_neg_q30(dq))), frac);
  endfunction

  function automatic longint sub_entry(longint unsigned dq, int frac);
    return to_frac(ln_q30(longint'(Q30_ONE - exp_neg_q30(dq))), frac);
  endfunction

endpackage

// ===== rtl/log_domain_add_sub_accumulate.sv =====
// top level: log-domain add / subtract / accumulate pipeline with stream ports
// path from an accepted input word to out_tvalid:
//   (input reg, then table read, then result reg)
// throughput: one word per cycle while out_tready holds; an accumulate right behind
//   another accumulate is held until the first one retires and writes back the running sum
// reset: after rst_n the correction tables are loaded from constants with in_tready low;
//   the running sum resets to missing
`timescale 1ns / 1ps
module log_domain_add_sub_accumulate #(
  parameter int VALUE_WIDTH = ldasa_pkg::DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = ldasa_pkg::DEF_FRAC_BITS,
  parameter int TABLE_DEPTH = ldasa_pkg::DEF_TABLE_DEPTH,
  localparam int IN_DW      = ((2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW     = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // x_value, y_value
  input  logic [6:0]        in_tuser,   // opcode[1:0], x_kind[3:2], y_kind[5:4], start_run[6]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // result_value
  output logic [3:0]        out_tuser   // result_kind[2:0], overflow[3]
);
  import ldasa_pkg::*;

  localparam int EW    = FRAC_BITS + RANGE_LOG2 + 1;
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // table load after reset
  logic              filling, fill_wr_en;
  logic [IDX_W-1:0]  fill_addr;
  logic [2*EW-1:0]   fill_data;

  // input stage registers
  logic                          s1_valid_r;
  op_t                           s1_op_r;
  logic signed [VALUE_WIDTH-1:0] s1_xv_r, s1_yv_r;
  kind_t                         s1_xk_r, s1_yk_r;
  logic                          s1_start_r;

  // table stage registers; the table word itself is held inside the ram
  logic                          s2_valid_r;
  ctl_t                          s2_ctl_r;
  logic signed [VALUE_WIDTH-1:0] s2_base_r;
  logic [2*EW-1:0]               tab_word;

  // output registers
  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_value_r;
  kind_t                         out_kind_r;
  logic                          out_ovf_r;

  // running sum
  logic signed [VALUE_WIDTH-1:0] running_value_r;
  kind_t                         running_kind_r;

  // stage handshakes
  logic in_acc, s1_adv, s2_adv, acc_hazard;

  // front stage results
  kind_t                         run_k;
  ctl_t                          f_ctl;
  logic signed [VALUE_WIDTH-1:0] f_base;
  logic [IDX_W-1:0]              f_idx;

  // correction stage results
  logic signed [VALUE_WIDTH-1:0] b_value;
  kind_t                         b_kind;
  logic                          b_ovf;

  // an accumulate must see the sum left by the accumulate ahead of it
  assign acc_hazard = (s1_op_r == OP_ACC) && s2_valid_r && s2_ctl_r.is_acc;
  assign s2_adv     = s2_valid_r && (!out_valid_r || out_tready);
  assign s1_adv     = s1_valid_r && !acc_hazard && (!s2_valid_r || s2_adv);
  assign in_tready  = !filling && (!s1_valid_r || s1_adv);
  assign in_acc     = in_tvalid && in_tready;

  ldasa_fill #(
    .FRAC_BITS   (FRAC_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .filling (filling),
    .wr_en   (fill_wr_en),
    .wr_addr (fill_addr),
    .wr_data (fill_data)
  );

  // start_run clears the running sum just for this accumulate
  assign run_k = s1_start_r ? K_MISS : running_kind_r;

  ldasa_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .opcode    (s1_op_r),
    .x_value   (s1_xv_r),
    .x_kind    (s1_xk_r),
    .y_value   (s1_yv_r),
    .y_kind    (s1_yk_r),
    .run_value (running_value_r),
    .run_kind  (run_k),
    .ctl       (f_ctl),
    .base      (f_base),
    .idx       (f_idx)
  );

  // one word per entry: subtract table above, add table below
  ldasa_ram #(
    .WIDTH (2 * EW),
    .DEPTH (TABLE_DEPTH)
  ) u_tab (
    .clk     (clk),
    .wr_en   (fill_wr_en),
    .wr_addr (fill_addr),
    .wr_data (fill_data),
    .rd_en   (s1_adv),
    .rd_addr (f_idx),
    .rd_data (tab_word)
  );

  ldasa_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .ctl          (s2_ctl_r),
    .base         (s2_base_r),
    .tab_word     (tab_word),
    .result_value (b_value),
    .result_kind  (b_kind),
    .overflow     (b_ovf)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      running_kind_r <= K_MISS;
      running_value_r <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // write back the running sum as the accumulate retires
      if (s2_adv && s2_ctl_r.is_acc) begin
        running_kind_r  <= b_kind;
        running_value_r <= (b_kind == K_FIN) ? b_value : '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= op_t'(in_tuser[1:0]);
      s1_xk_r    <= kind_t'({1'b0, in_tuser[3:2]});
      s1_yk_r    <= kind_t'({1'b0, in_tuser[5:4]});
      s1_start_r <= in_tuser[6];
      s1_xv_r    <= in_tdata[VALUE_WIDTH-1:0];
      s1_yv_r    <= in_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
    end
    if (s1_adv) begin
      s2_ctl_r  <= f_ctl;
      s2_base_r <= f_base;
    end
    if (s2_adv) begin
      out_value_r <= b_value;
      out_kind_r  <= b_kind;
      out_ovf_r   <= b_ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(unsigned'(out_value_r));
  assign out_tuser  = {out_ovf_r, out_kind_r};

endmodule

// ===== rtl/ldasa_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module ldasa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ldasa_fill.sv =====
// correction table constants and the sweep that loads them into the table ram after reset
`timescale 1ns / 1ps
module ldasa_fill #(
  parameter int FRAC_BITS   = ldasa_pkg::DEF_FRAC_BITS,
  parameter int TABLE_DEPTH = ldasa_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  output logic                                      filling,
  output logic                                      wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]            wr_addr,
  output logic [2*(FRAC_BITS+ldasa_pkg::RANGE_LOG2+1)-1:0] wr_data
);
  import ldasa_pkg::*;

  localparam int EW    = FRAC_BITS + RANGE_LOG2 + 1;
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [2*EW-1:0] rom_w [TABLE_DEPTH];

  // entry k sits at the midpoint of its difference bucket
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_ent
    localparam longint unsigned DQ =
      (64'(2 * k + 1) << (29 + RANGE_LOG2)) / 64'(TABLE_DEPTH);
    localparam longint ADD_V = add_entry(DQ, FRAC_BITS);
    localparam longint SUB_V = sub_entry(DQ, FRAC_BITS);
    assign rom_w[k] = {SUB_V[EW-1:0], ADD_V[EW-1:0]};
  end

  logic             filling_r;
  logic [IDX_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filling_r <= 1'b1;
      cnt_r     <= '0;
    end else if (filling_r) begin
      if (cnt_r == IDX_W'(TABLE_DEPTH - 1)) begin
        filling_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign filling = filling_r;
  assign wr_en   = filling_r;
  assign wr_addr = cnt_r;
  assign wr_data = rom_w[cnt_r];

endmodule

// ===== rtl/ldasa_front.sv =====
// operand resolution, special cases and table index for one word
`timescale 1ns / 1ps
module ldasa_front #(
  parameter int VALUE_WIDTH = ldasa_pkg::DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = ldasa_pkg::DEF_FRAC_BITS,
  parameter int TABLE_DEPTH = ldasa_pkg::DEF_TABLE_DEPTH
) (
  input  ldasa_pkg::op_t                    opcode,
  input  logic signed [VALUE_WIDTH-1:0]     x_value,
  input  ldasa_pkg::kind_t                  x_kind,
  input  logic signed [VALUE_WIDTH-1:0]     y_value,
  input  ldasa_pkg::kind_t                  y_kind,
  input  logic signed [VALUE_WIDTH-1:0]     run_value,
  input  ldasa_pkg::kind_t                  run_kind,
  output ldasa_pkg::ctl_t                   ctl,
  output logic signed [VALUE_WIDTH-1:0]     base,
  output logic [$clog2(TABLE_DEPTH)-1:0]    idx
);
  import ldasa_pkg::*;

  localparam int LIM_W  = FRAC_BITS + RANGE_LOG2;
  localparam int DIFF_W = (VALUE_WIDTH > LIM_W) ? VALUE_WIDTH + 1 : LIM_W + 1;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int PROD_W = LIM_W + IDX_W + 1;

  logic signed [VALUE_WIDTH-1:0] a_v, b_v, hi_v, lo_v;
  kind_t                         a_k, b_k;
  logic                          a_gt, a_eq, both_fin, any_inf, far;
  logic [DIFF_W-1:0]             diff;
  logic [PROD_W-1:0]             prod;
  nf_t                           nf;

  // accumulate folds x into the running sum, the others combine x and y
  always_comb begin
    if (opcode == OP_ACC) begin
      a_v = run_value;
      a_k = run_kind;
      b_v = x_value;
      b_k = x_kind;
    end else begin
      a_v = x_value;
      a_k = x_kind;
      b_v = y_value;
      b_k = y_kind;
    end
  end

  assign a_gt     = (a_v > b_v);
  assign a_eq     = (a_v == b_v);
  assign hi_v     = a_gt ? a_v : b_v;
  assign lo_v     = a_gt ? b_v : a_v;
  assign diff     = DIFF_W'(hi_v) - DIFF_W'(lo_v);
  assign far      = |diff[DIFF_W-1:LIM_W];
  assign prod     = PROD_W'(diff[LIM_W-1:0]) * PROD_W'(TABLE_DEPTH);
  assign idx      = prod[LIM_W +: IDX_W];
  assign both_fin = (a_k == K_FIN) && (b_k == K_FIN);
  assign any_inf  = (a_k == K_PINF) || (a_k == K_NINF) || (b_k == K_PINF) || (b_k == K_NINF);
  assign nf       = nf_max(a_k, b_k);

  always_comb begin
    ctl.kind    = K_BAD;
    ctl.corr_en = 1'b0;
    ctl.use_sub = 1'b0;
    ctl.is_acc  = (opcode == OP_ACC);
    base        = a_v;
    unique case (opcode)
      OP_ADD, OP_ACC: begin
        if (both_fin) begin
          ctl.kind    = K_FIN;
          ctl.corr_en = !far;
          base        = hi_v;
        end else begin
          ctl.kind = nf.kind;
          base     = nf.take_b ? b_v : a_v;
        end
      end
      OP_SUB: begin
        ctl.use_sub = 1'b1;
        if (any_inf) begin
          ctl.kind = nf.kind;
          base     = nf.take_b ? b_v : a_v;
        end else if (a_k == K_MISS) begin
          ctl.kind = K_MISS;
        end else if (b_k == K_MISS) begin
          ctl.kind = a_k;
        end else if (a_eq) begin
          ctl.kind = K_NINF;
        end else if (!a_gt) begin
          ctl.kind = K_BAD;
        end else begin
          ctl.kind    = K_FIN;
          ctl.corr_en = !far;
          base        = a_v;
        end
      end
      default: begin
        ctl.kind = K_BAD;
      end
    endcase
  end

endmodule

// ===== rtl/ldasa_back.sv =====
// adds the table correction to the base value and saturates to the value range
`timescale 1ns / 1ps
module ldasa_back #(
  parameter int VALUE_WIDTH = ldasa_pkg::DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = ldasa_pkg::DEF_FRAC_BITS
) (
  input  ldasa_pkg::ctl_t                                   ctl,
  input  logic signed [VALUE_WIDTH-1:0]                     base,
  input  logic [2*(FRAC_BITS+ldasa_pkg::RANGE_LOG2+1)-1:0]  tab_word,
  output logic signed [VALUE_WIDTH-1:0]                     result_value,
  output ldasa_pkg::kind_t                                  result_kind,
  output logic                                              overflow
);
  import ldasa_pkg::*;

  localparam int EW    = FRAC_BITS + RANGE_LOG2 + 1;
  localparam int SUM_W = ((VALUE_WIDTH > EW) ? VALUE_WIDTH : EW) + 1;
  localparam logic signed [SUM_W-1:0] HI_S = (SUM_W'(1) << (VALUE_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] LO_S = -HI_S - SUM_W'(1);

  logic signed [EW-1:0]    entry;
  logic signed [SUM_W-1:0] sum;

  // upper half of the word is the subtract table, lower half the add table
  assign entry = ctl.use_sub ? tab_word[2*EW-1:EW] : tab_word[EW-1:0];
  assign sum   = SUM_W'(base) + (ctl.corr_en ? SUM_W'(entry) : '0);

  always_comb begin
    result_kind  = ctl.kind;
    result_value = '0;
    overflow     = 1'b0;
    if (ctl.kind == K_FIN) begin
      if (sum > HI_S) begin
        result_value = HI_S[VALUE_WIDTH-1:0];
        overflow     = 1'b1;
      end else if (sum < LO_S) begin
        result_value = LO_S[VALUE_WIDTH-1:0];
        overflow     = 1'b1;
      end else begin
        result_value = sum[VALUE_WIDTH-1:0];
      end
    end
  end

endmodule
